FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Plain property, checked on every edge out of reset.
`define GTRG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Same-cycle implication.
`define GTRG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`else
`define GTRG_ASSERT(lbl, clk, rstn, prop, msg)
`define GTRG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: src/gtrg_pkg.sv
// ----------------------------------------------------------------------------
// gtrg_pkg
// Shared types, register indices and the 6x4 glyph ROM.
// ----------------------------------------------------------------------------
package gtrg_pkg;

  localparam int unsigned ROWS_PER_GLYPH = 6;
  localparam int unsigned COLS_PER_GLYPH = 4;
  localparam int unsigned GLYPH_BITS     = ROWS_PER_GLYPH * COLS_PER_GLYPH;
  localparam int unsigned IDX_W          = $clog2(GLYPH_BITS);

  // Config register indices
  localparam logic [1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y   = 2'd1;
  localparam logic [1:0] CFG_PIXEL_SIZE = 2'd2;
  localparam logic [1:0] CFG_DRAW_COLOR = 2'd3;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [7:0]  pixel_size;
    logic [31:0] draw_color;
  } cfg_t;

  // One classified character: lit bits (bit row*4+col) and its cursor.
  typedef struct packed {
    logic [GLYPH_BITS-1:0] bits;
    logic [31:0]           cursor;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic busy;
    logic bits_nz;
  } bk_stat_t;

  function automatic logic [3:0] rev4(input logic [3:0] v);
    rev4 = {v[0], v[1], v[2], v[3]};
  endfunction

  // Leftmost column of a row nibble is its MSB; it goes to the lowest bit.
  function automatic logic [GLYPH_BITS-1:0] pack_rows(
    input logic [3:0] r0, input logic [3:0] r1, input logic [3:0] r2,
    input logic [3:0] r3, input logic [3:0] r4, input logic [3:0] r5);
    pack_rows = {rev4(r5), rev4(r4), rev4(r3), rev4(r2), rev4(r1), rev4(r0)};
  endfunction

  // Code must already be upper case. Zero means blank glyph.
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
    case (code)
      8'h30, 8'h4F: glyph_bits = pack_rows(4'h6, 4'h9, 4'h9, 4'h9, 4'h9, 4'h6); // 0 O
      8'h31:        glyph_bits = pack_rows(4'h2, 4'h6, 4'h2, 4'h2, 4'h2, 4'h7);
      8'h32:        glyph_bits = pack_rows(4'h6, 4'h9, 4'h2, 4'h4, 4'h8, 4'hF);
      8'h33:        glyph_bits = pack_rows(4'h6, 4'h9, 4'h2, 4'h1, 4'h9, 4'h6);
      8'h34:        glyph_bits = pack_rows(4'h1, 4'h3, 4'h5, 4'hF, 4'h1, 4'h1);
      8'h35, 8'h53: glyph_bits = pack_rows(4'hF, 4'h8, 4'hE, 4'h1, 4'h9, 4'h6); // 5 S
      8'h36:        glyph_bits = pack_rows(4'h6, 4'h8, 4'hE, 4'h9, 4'h9, 4'h6);
      8'h37:        glyph_bits = pack_rows(4'hF, 4'h1, 4'h2, 4'h4, 4'h4, 4'h4);
      8'h38:        glyph_bits = pack_rows(4'h6, 4'h9, 4'h6, 4'h9, 4'h9, 4'h6);
      8'h39:        glyph_bits = pack_rows(4'h6, 4'h9, 4'h9, 4'h7, 4'h1, 4'h6);
      8'h25:        glyph_bits = pack_rows(4'h9, 4'h1, 4'h2, 4'h4, 4'h8, 4'h9); // %
      8'h52:        glyph_bits = pack_rows(4'hE, 4'h9, 4'hE, 4'hA, 4'h9, 4'h9); // R
      8'h50:        glyph_bits = pack_rows(4'hE, 4'h9, 4'hE, 4'h8, 4'h8, 4'h8); // P
      8'h4D, 8'h4E: glyph_bits = pack_rows(4'h9, 4'hD, 4'hB, 4'h9, 4'h9, 4'h9); // M N
      8'h44:        glyph_bits = pack_rows(4'hE, 4'h9, 4'h9, 4'h9, 4'h9, 4'hE); // D
      8'h54:        glyph_bits = pack_rows(4'hF, 4'h6, 4'h6, 4'h6, 4'h6, 4'h6); // T
      8'h48:        glyph_bits = pack_rows(4'h9, 4'h9, 4'hF, 4'h9, 4'h9, 4'h9); // H
      8'h46:        glyph_bits = pack_rows(4'hF, 4'h8, 4'hE, 4'h8, 4'h8, 4'h8); // F
      8'h55:        glyph_bits = pack_rows(4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h6); // U
      8'h45:        glyph_bits = pack_rows(4'hF, 4'h8, 4'hE, 4'h8, 4'h8, 4'hF); // E
      8'h4C:        glyph_bits = pack_rows(4'h8, 4'h8, 4'h8, 4'h8, 4'h8, 4'hF); // L
      8'h43:        glyph_bits = pack_rows(4'h7, 4'h8, 4'h8, 4'h8, 4'h8, 4'h7); // C
      8'h57:        glyph_bits = pack_rows(4'h9, 4'h9, 4'h9, 4'hB, 4'hD, 4'h9); // W
      default:      glyph_bits = '0;
    endcase
  endfunction

endpackage

FILE: src/gtrg_front.sv
// ----------------------------------------------------------------------------
// gtrg_front
// Accepts characters, looks up the glyph and tracks the text cursor.
// ----------------------------------------------------------------------------
module gtrg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gtrg_pkg::cfg_t      cfg_i,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [7:0]          char_code_i,
  input  logic                text_start_i,
  input  gtrg_pkg::fifo_stat_t fifo_stat_i,
  output logic                push_o,
  output gtrg_pkg::q_entry_t  entry_o
);
  import gtrg_pkg::*;

  logic [31:0] cursor_q, cursor_d;
  logic [31:0] base;
  logic [7:0]  code_uc;
  logic [10:0] advance;
  logic        accept;

  assign s_ready_o = !fifo_stat_i.full;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    code_uc = char_code_i;
    if (char_code_i inside {[8'h61:8'h7A]}) begin
      code_uc = char_code_i - 8'h20;
    end
  end

  assign base    = text_start_i ? {{16{cfg_i.origin_x[15]}}, cfg_i.origin_x} : cursor_q;
  // (COLS + 1) * size = 4 * size + size
  assign advance = {1'b0, cfg_i.pixel_size, 2'b00} + {3'b000, cfg_i.pixel_size};

  assign entry_o.bits   = glyph_bits(code_uc);
  assign entry_o.cursor = base;
  // Blank glyphs only move the cursor.
  assign push_o         = accept && (entry_o.bits != '0);

  assign cursor_d = accept ? (base + {21'd0, advance}) : cursor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else begin
      cursor_q <= cursor_d;
    end
  end

endmodule

FILE: src/gtrg_fifo.sv
// ----------------------------------------------------------------------------
// gtrg_fifo
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module gtrg_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  gtrg_pkg::q_entry_t          entry_i,
  input  logic                        pop_i,
  output gtrg_pkg::q_entry_t          entry_o,
  output gtrg_pkg::fifo_stat_t        stat_o,
  output logic [$clog2(DEPTH+1)-1:0]  count_o
);
  import gtrg_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign count_o      = cnt_q;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: src/gtrg_back.sv
// ----------------------------------------------------------------------------
// gtrg_back
// Scans one glyph a bit per cycle, holding on a lit bit while the output is stalled, and emits a rectangle per lit bit.
// ----------------------------------------------------------------------------
module gtrg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gtrg_pkg::cfg_t      cfg_i,
  input  gtrg_pkg::q_entry_t  entry_i,
  input  gtrg_pkg::fifo_stat_t fifo_stat_i,
  output logic                pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [103:0]        m_data_o,
  output logic                m_last_o,
  output gtrg_pkg::bk_stat_t  stat_o
);
  import gtrg_pkg::*;

  logic                  busy_q, busy_d;
  logic [GLYPH_BITS-1:0] bits_q, bits_d, bits_left;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [31:0]           cursor_q, cursor_d;
  logic                  ovalid_q, ovalid_d;
  logic [31:0]           rx_q, rx_d, ry_q, ry_d, rcol_q, rcol_d;
  logic [7:0]            rside_q, rside_d;
  logic                  rlast_q, rlast_d;
  logic                  out_free, lit, step, load;
  logic [1:0]            col;
  logic [2:0]            row;
  logic [9:0]            x_off;
  logic [10:0]           y_off;

  assign col       = idx_q[1:0];
  assign row       = idx_q[IDX_W-1:2];
  assign lit       = bits_q[idx_q];
  assign out_free  = !ovalid_q || m_ready_i;
  assign step      = busy_q && (!lit || out_free);
  assign bits_left = bits_q & ~(GLYPH_BITS'(1) << idx_q);
  assign load      = !busy_q && !fifo_stat_i.empty;
  assign pop_o     = load;

  assign x_off = 10'(col) * 10'(cfg_i.pixel_size);
  assign y_off = 11'(row) * 11'(cfg_i.pixel_size);

  always_comb begin
    busy_d   = busy_q;
    bits_d   = bits_q;
    idx_d    = idx_q;
    cursor_d = cursor_q;
    if (load) begin
      busy_d   = 1'b1;
      bits_d   = entry_i.bits;
      idx_d    = '0;
      cursor_d = entry_i.cursor;
    end else if (step) begin
      bits_d = bits_left;
      idx_d  = idx_q + 1'b1;
      busy_d = (bits_left != '0);
    end
  end

  always_comb begin
    ovalid_d = ovalid_q && !m_ready_i;
    rx_d     = rx_q;
    ry_d     = ry_q;
    rside_d  = rside_q;
    rcol_d   = rcol_q;
    rlast_d  = rlast_q;
    if (step && lit) begin
      ovalid_d = 1'b1;
      rx_d     = cursor_q + {22'd0, x_off};
      ry_d     = {{16{cfg_i.origin_y[15]}}, cfg_i.origin_y} + {21'd0, y_off};
      rside_d  = cfg_i.pixel_size;
      rcol_d   = cfg_i.draw_color;
      rlast_d  = (bits_left == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
      idx_q    <= '0;
      bits_q   <= '0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
      idx_q    <= idx_d;
      bits_q   <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q <= cursor_d;
    rx_q     <= rx_d;
    ry_q     <= ry_d;
    rside_q  <= rside_d;
    rcol_q   <= rcol_d;
    rlast_q  <= rlast_d;
  end

  assign m_valid_o      = ovalid_q;
  assign m_data_o       = {rcol_q, rside_q, ry_q, rx_q};
  assign m_last_o       = rlast_q;
  assign stat_o.busy    = busy_q;
  assign stat_o.bits_nz = (bits_q != '0);

endmodule

FILE: src/glyph_text_rect_generator_top.sv
// ----------------------------------------------------------------------------
// glyph_text_rect_generator_top
// Text characters in, one lit-pixel rectangle per output word out.
// ----------------------------------------------------------------------------
// Channel   Dir  Word contents                              Accepted when
// s_axis    in   tdata char_code, tuser text_start          tvalid & tready
// m_axis    out  tdata x,y,side,colour; tlast last_rect     tvalid & tready
// cfg       in   register index + data, no read-back        cfg_we_i high
//
// Front takes one character a cycle while the queue has room; blank glyphs
// only move the cursor. Back scans the 24 glyph bits one per cycle and stops
// after the last lit bit; it loads the next character from the queue only
// once idle. A stalled m_axis holds the back on lit bits only. Reset clears
// control state and the cursor; no clear pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glyph_text_rect_generator_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // slave side
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] char_code
  input  logic          s_axis_tuser,   // [0] text_start
  // master side
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [103:0]  m_axis_tdata,   // [31:0] rect_x, [63:32] rect_y,
                                        // [71:64] rect_side, [103:72] rect_color
  output logic          m_axis_tlast,   // last_rect
  // configuration
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i
);
  import gtrg_pkg::*;

  cfg_t       cfg_q, cfg_d;
  q_entry_t   fe_entry, bk_entry;
  fifo_stat_t fifo_stat;
  bk_stat_t   bk_stat;
  logic       push, pop;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  // Register file
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X:   cfg_d.origin_x   = cfg_wdata_i[15:0];
        CFG_ORIGIN_Y:   cfg_d.origin_y   = cfg_wdata_i[15:0];
        CFG_PIXEL_SIZE: cfg_d.pixel_size = cfg_wdata_i[7:0];
        CFG_DRAW_COLOR: cfg_d.draw_color = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x   <= '0;
      cfg_q.origin_y   <= '0;
      cfg_q.pixel_size <= 8'd1;
      cfg_q.draw_color <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gtrg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .char_code_i  (s_axis_tdata),
    .text_start_i (s_axis_tuser),
    .fifo_stat_i  (fifo_stat),
    .push_o       (push),
    .entry_o      (fe_entry)
  );

  gtrg_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (fe_entry),
    .pop_i   (pop),
    .entry_o (bk_entry),
    .stat_o  (fifo_stat),
    .count_o (q_count)
  );

  gtrg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .entry_i     (bk_entry),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast),
    .stat_o      (bk_stat)
  );

  // Scanning a glyph always leaves a lit bit pending until it finishes
  `GTRG_ASSERT_IMPL(a_busy_bits, clk_i, rst_ni, bk_stat.busy, bk_stat.bits_nz, "back busy with empty glyph")
  // Queue occupancy never exceeds its depth
  `GTRG_ASSERT(a_q_count, clk_i, rst_ni, q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH), "queue count overrun")
  // Back only loads from a non-empty queue
  `GTRG_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop, !fifo_stat.empty, "pop from empty queue")
  // Front never pushes into a full queue
  `GTRG_ASSERT_IMPL(a_push_room, clk_i, rst_ni, push, !fifo_stat.full, "push into full queue")

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the glyph rectangle generator. A software glyph
// renderer in the bench predicts every lit-pixel rectangle for each accepted
// character. A monitor compares each output word against the oldest
// prediction. Stimulus is a short directed part (case folding, shared and
// blank glyphs, register extremes, wrap, zero pixel size) and then random
// text under three stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import gtrg_pkg::*;

  localparam int DRAIN_CYC   = 150;   // margin for a full queue of 4 chars to drain, plus slack
  localparam int STALL_LIMIT = 5000;  // cycles with no word moving on either side
  localparam int RAND_ITEMS  = 28;    // per stall pattern

  // One expected rectangle; field order matches the bench's unpacking below.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  side;
    logic [31:0] color;
    logic        last;
  } rect_t;

  logic          clk_i         = 1'b0;
  logic          rst_ni        = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [7:0]    s_axis_tdata  = '0;
  logic          s_axis_tuser  = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [103:0]  m_axis_tdata;
  logic          m_axis_tlast;
  logic          cfg_we_i      = 1'b0;
  logic [1:0]    cfg_idx_i     = CFG_ORIGIN_X;
  logic [31:0]   cfg_wdata_i   = '0;

  // Bench copy of the register file and the text cursor (reset values).
  logic [15:0]   org_x_sh  = 16'h0000;
  logic [15:0]   org_y_sh  = 16'h0000;
  logic [7:0]    px_sh     = 8'd1;
  logic [31:0]   colour_sh = 32'hFFFF_FFFF;
  logic [31:0]   cursor_x  = 32'h0;

  rect_t         pending_rects[$];
  rect_t         got_rect;
  rect_t         want_rect;
  int            mismatch_cnt = 0;
  int            quiet_cycles = 0;
  int            src_idle_pct = 23;
  int            snk_idle_pct = 73;
  string         glyph_set    = "0123456789%RPMSDTHFUELCONW";

  glyph_text_rect_generator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Glyph renderer
  // --------------------------------------------------------------------------

  // Six row nibbles, top row in the high nibble; within a row the MSB is the
  // leftmost column. Zero is a blank glyph.
  function automatic logic [23:0] glyph_nibbles(input logic [7:0] up);
    case (up)
      "0", "O": return 24'h699996;
      "1":      return 24'h262227;
      "2":      return 24'h69248F;
      "3":      return 24'h692196;
      "4":      return 24'h135F11;
      "5", "S": return 24'hF8E196;
      "6":      return 24'h68E996;
      "7":      return 24'hF12444;
      "8":      return 24'h696996;
      "9":      return 24'h699716;
      "%":      return 24'h912489;
      "R":      return 24'hE9EA99;
      "P":      return 24'hE9E888;
      "M", "N": return 24'h9DB999;   // M and N share a glyph
      "D":      return 24'hE9999E;
      "T":      return 24'hF66666;
      "H":      return 24'h99F999;
      "F":      return 24'hF8E888;
      "U":      return 24'h999996;
      "E":      return 24'hF8E88F;
      "L":      return 24'h88888F;
      "C":      return 24'h788887;
      "W":      return 24'h999BD9;
      default:  return 24'h000000;
    endcase
  endfunction

  // Queues the rectangles one character produces and moves the cursor on.
  function automatic void render_char(input logic [7:0] code, input logic start);
    logic [7:0]  up;
    logic [23:0] nib;
    logic [31:0] ps;
    logic [31:0] y0;
    rect_t       cur;
    bit          have;
    up   = code;
    ps   = {24'd0, px_sh};
    y0   = {{16{org_y_sh[15]}}, org_y_sh};
    have = 1'b0;
    cur  = '0;
    if (start)
      cursor_x = {{16{org_x_sh[15]}}, org_x_sh};
    if (up >= "a" && up <= "z")
      up = up - 8'd32;                 // fold ASCII lower case only
    nib = glyph_nibbles(up);
    for (int r = 0; r < ROWS_PER_GLYPH; r++) begin
      for (int c = 0; c < COLS_PER_GLYPH; c++) begin
        if (nib[23 - 4 * r - c]) begin
          if (have)
            pending_rects.push_back(cur);
          cur.x     = cursor_x + c * ps;
          cur.y     = y0 + r * ps;
          cur.side  = px_sh;
          cur.color = colour_sh;
          cur.last  = 1'b0;
          have      = 1'b1;
        end
      end
    end
    if (have) begin
      cur.last = 1'b1;
      pending_rects.push_back(cur);
    end
    // blank glyphs still advance; wraps modulo 2^32
    cursor_x = cursor_x + (COLS_PER_GLYPH + 1) * ps;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one character, predicting its output once the word is taken.
  // tvalid is left high on return so back-to-back words need no re-raise.
  task automatic push_char(input logic [7:0] code, input logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    render_char(code, start);
  endtask

  // Stop sending, let every predicted word arrive, then idle for a margin
  // before the next register writes.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_rects.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // Only called with the block idle; cfg_we_i is dropped again before returning.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_ORIGIN_X:   org_x_sh  = val[15:0];
      CFG_ORIGIN_Y:   org_y_sh  = val[15:0];
      CFG_PIXEL_SIZE: px_sh     = val[7:0];
      CFG_DRAW_COLOR: colour_sh = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [15:0] ox, input logic [15:0] oy,
                           input logic [7:0] ps, input logic [31:0] col);
    write_reg(CFG_ORIGIN_X, {16'd0, ox});
    write_reg(CFG_ORIGIN_Y, {16'd0, oy});
    write_reg(CFG_PIXEL_SIZE, {24'd0, ps});
    write_reg(CFG_DRAW_COLOR, col);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset register values; M and N must come out identical.
  task automatic test_reset_defaults();
    push_char("0", 1'b1);
    push_char("m", 1'b0);
    push_char("N", 1'b0);
    push_char("%", 1'b0);
    settle();
  endtask

  // Blank glyphs (space, NUL, top half of the byte range, unsupported lower
  // case, '{') must emit nothing but still advance the cursor; w folds to W.
  task automatic test_blank_and_case();
    push_char(" ", 1'b0);
    push_char(8'h00, 1'b0);
    push_char(8'h80, 1'b0);
    push_char(8'hFF, 1'b1);
    push_char("z", 1'b0);
    push_char("w", 1'b0);
    push_char(8'h7B, 1'b0);
    settle();
  endtask

  // Register extremes; negative origins push coordinates through the 32-bit
  // wrap point.
  task automatic test_extreme_config();
    write_all(16'h7FFF, 16'h8000, 8'd255, 32'h0000_0000);
    push_char("8", 1'b1);
    push_char("W", 1'b0);
    settle();
    write_all(16'hFFFF, 16'hFFFF, 8'd255, 32'hFFFF_FFFF);
    push_char("H", 1'b1);
    push_char("8", 1'b0);
    settle();
  endtask

  // Pixel size of zero: all rectangles collapse onto the cursor and the
  // cursor stays put.
  task automatic test_zero_pixel();
    write_all(16'h1234, 16'hEDCB, 8'd0, 32'hA5A5_5A5A);
    push_char("8", 1'b1);
    push_char("8", 1'b0);
    push_char(" ", 1'b0);
    settle();
  endtask

  // Random registers (extremes favoured), then random text: mostly
  // supported glyphs in either case, the rest any byte.
  task automatic test_random_text(input int src_pct, input int snk_pct);
    logic [15:0] ox;
    logic [15:0] oy;
    logic [7:0]  ps;
    logic [7:0]  ch;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    case ($urandom_range(3))
      0:       ox = 16'h8000;
      1:       ox = 16'h7FFF;
      default: ox = 16'($urandom_range(16'hFFFF));
    endcase
    case ($urandom_range(3))
      0:       oy = 16'h8000;
      1:       oy = 16'h7FFF;
      default: oy = 16'($urandom_range(16'hFFFF));
    endcase
    case ($urandom_range(3))
      0:       ps = 8'd1;
      1:       ps = 8'd255;
      default: ps = 8'($urandom_range(255, 1));
    endcase
    write_all(ox, oy, ps, $urandom());
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(9) < 7) begin
        ch = glyph_set[$urandom_range(glyph_set.len() - 1)];
        if (ch >= "A" && $urandom_range(1) == 1)
          ch = ch + 8'd32;
      end else begin
        ch = 8'($urandom_range(255));
      end
      push_char(ch, $urandom_range(7) == 0);
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Output monitor and back-pressure
  // --------------------------------------------------------------------------

  task automatic log_mismatch(input string what, input rect_t want, input rect_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: exp x=%h y=%h side=%h colour=%h last=%b | %s%h %s%h %s%h %s%h %s%b",
               $time, what, want.x, want.y, want.side, want.color, want.last,
               "got x=", got.x, "y=", got.y, "side=", got.side,
               "colour=", got.color, "last=", got.last);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_rect = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[71:64],
                  m_axis_tdata[103:72], m_axis_tlast};
      if (pending_rects.size() == 0) begin
        log_mismatch("unexpected word", '0, got_rect);
      end else begin
        want_rect = pending_rects.pop_front();
        if (got_rect.x !== want_rect.x || got_rect.y !== want_rect.y ||
            got_rect.side !== want_rect.side || got_rect.color !== want_rect.color ||
            got_rect.last !== want_rect.last)
          log_mismatch("wrong word", want_rect, got_rect);
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog: any word moving on either side counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_blank_and_case();
    test_extreme_config();
    test_zero_pixel();
    test_random_text(23, 73);
    test_random_text(73, 23);
    test_random_text(0, 0);
    if (mismatch_cnt == 0 && pending_rects.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
